// ===== src/pls_pkg.sv =====
package pls_pkg;

  // Storage sizing.
  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;

  // Fixed port widths.
  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNTO_W = 5;

  // Derived widths.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_REAR  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_REAR  = 3'd3,
    OP_INS_POS   = 3'd4,
    OP_REM_POS   = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

// ===== src/positional_list_store.sv =====
// Channel  Handshake              Payload
// input    in_valid / in_stall    opcode, position, value_in
// output   out_valid / out_stall  status, value_out, count_out
//
// Each transaction is registered on entry, resolved combinationally by the
// decode and cell shift logic, and its result registered on exit.
// One transaction is accepted every cycle unless the output stalls; the list
// cells update in the same edge that loads the result register.
// Reset (rst, synchronous) empties the list and drops both valid flags.
// A stalled result holds the input register, which then stalls the input.
module positional_list_store
  import pls_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   opcode,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] value_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [DATA_W-1:0] value_out,
  output logic [CNTO_W-1:0] count_out
);

  // Input register.
  logic                   s1_valid;
  op_t                    s1_op;
  logic [POS_W-1:0]       s1_pos;
  logic [VALUE_WIDTH-1:0] s1_val;

  // List state.
  logic [VALUE_WIDTH-1:0] slots [CAPACITY];
  logic [CNT_W-1:0]       count;

  // Result register.
  status_t                res_status;
  logic [DATA_W-1:0]      res_value;
  logic [CNT_W-1:0]       res_count;

  // Resolved operation.
  status_t                status_next;
  logic [DATA_W-1:0]      value_next;
  logic [CNT_W-1:0]       count_next;
  logic                   do_ins;
  logic                   do_rem;
  logic [IDX_W-1:0]       idx;
  logic [CMP_W-1:0]       pos_c;
  logic [CMP_W-1:0]       cnt_c;
  logic                   full;
  logic                   empty;
  logic                   adv;

  // The input stage moves on whenever the result register is free.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_op  <= op_t'(opcode);
      s1_pos <= position;
      s1_val <= VALUE_WIDTH'(value_in);
    end
  end

  // Decode the operation against the current count.
  assign pos_c = CMP_W'(s1_pos);
  assign cnt_c = CMP_W'(count);
  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    status_next = ST_OK;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    idx         = '0;
    case (s1_op)
      OP_ADD_FRONT: begin
        if (full) status_next = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_ADD_REAR: begin
        idx = IDX_W'(count);
        if (full) status_next = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_REM_FRONT: begin
        if (empty) status_next = ST_UNDER;
        else do_rem = 1'b1;
      end
      OP_REM_REAR: begin
        idx = IDX_W'(count - CNT_W'(1));
        if (empty) status_next = ST_UNDER;
        else do_rem = 1'b1;
      end
      OP_INS_POS: begin
        idx = IDX_W'(pos_c - CMP_W'(1));
        if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) status_next = ST_RANGE;
        else if (full) status_next = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_REM_POS: begin
        idx = IDX_W'(pos_c - CMP_W'(1));
        if (pos_c == '0 || pos_c > cnt_c) status_next = ST_RANGE;
        else do_rem = 1'b1;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Removed value and new count.
  always_comb begin
    value_next = '0;
    count_next = count;
    if (do_rem) begin
      value_next = DATA_W'(slots[idx]);
      count_next = count - CNT_W'(1);
    end else if (do_ins) begin
      count_next = count + CNT_W'(1);
    end
  end

  // Cells from the index onward shift toward the rear on insert or toward the front on removal.
  always_ff @(posedge clk) begin
    if (s1_valid && adv) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (do_ins) begin
          if (IDX_W'(k) == idx) begin
            slots[k] <= s1_val;
          end else if (k > 0 && IDX_W'(k) > idx) begin
            slots[k] <= slots[(k > 0) ? k - 1 : 0];
          end
        end else if (do_rem) begin
          if (k < CAPACITY - 1 && IDX_W'(k) >= idx) begin
            slots[k] <= slots[(k < CAPACITY - 1) ? k + 1 : k];
          end
        end
      end
    end
  end

  // Count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        count <= count_next;
      end
    end
    if (adv && s1_valid) begin
      res_status <= status_next;
      res_value  <= value_next;
      res_count  <= count_next;
    end
  end

  assign status    = res_status;
  assign value_out = res_value;
  assign count_out = CNTO_W'(res_count);

`ifndef NO_ASSERTIONS
  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list count exceeds capacity");

  // A failed operation returns no value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_status != ST_OK |-> res_value == '0)
    else $error("nonzero value on failed transaction");

  // A failed operation leaves the count alone.
  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv && status_next != ST_OK |=> count == $past(count))
    else $error("count changed on failed transaction");

  // The reported count is the list count after the operation.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv |=> res_count == count)
    else $error("reported count differs from list count");
`endif

endmodule
